// ----- sv/fdl_pkg.sv -----
`default_nettype none

package fdl_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 10;
    localparam int COEFF_W  = 16;

    // Default ring size and coefficient reset (0.5 in Q0.16)
    localparam int                 SIZE_LOG2_DEF = 10;
    localparam logic [COEFF_W-1:0] COEFF_RESET   = 16'h8000;

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Request codes
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Fetched sample pair handed to the interpolator
    typedef struct packed {
        logic    vld;
        sample_t x1;
        sample_t x2;
    } pair_t;

    // Interpolated result
    typedef struct packed {
        logic    vld;
        sample_t y;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/fdl_ifs.sv -----
`default_nettype none

// Request channel: sample writes and delayed reads
interface fdl_req_if;
    logic                   valid;
    logic                   ready;
    fdl_pkg::req_t          req_type;
    fdl_pkg::sample_t       sample_in;
    logic [fdl_pkg::DELAY_W-1:0] delay_int;

    modport source (output valid, output req_type, output sample_in, output delay_int,
                    input ready);
    modport sink   (input valid, input req_type, input sample_in, input delay_int,
                    output ready);
endinterface

// Result channel: interpolated samples
interface fdl_res_if;
    logic             valid;
    logic             ready;
    fdl_pkg::sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// Coefficient write channel
interface fdl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fdl_pkg::COEFF_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/fdl_interp.sv -----
`default_nettype none

// Two-stage allpass interpolator: multiply, then add / round / saturate.
// Holds the previous output, which feeds back into the next multiply.
module fdl_interp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fdl_pkg::COEFF_W-1:0] coeff,
    input  fdl_pkg::pair_t              pair,
    output fdl_pkg::result_t            result
);

    localparam int SW    = fdl_pkg::SAMPLE_W;
    localparam int PROD_W = fdl_pkg::COEFF_W + 1 + SW + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - 16;

    logic signed [SW:0]                diff;
    logic signed [fdl_pkg::COEFF_W:0]  coeff_s;
    logic signed [PROD_W-1:0]          prod_next;
    logic signed [PROD_W-1:0]          prod_reg;
    fdl_pkg::sample_t                  x1_reg;
    logic                              s1_vld_reg;
    logic signed [ACC_W-1:0]           acc;
    logic signed [Q_W-1:0]             q;
    fdl_pkg::sample_t                  y_next;
    fdl_pkg::sample_t                  y_reg;
    logic                              y_vld_reg;
    fdl_pkg::sample_t                  prev_reg;

    // Stage 1: c * (x2 - y_prev)
    assign diff      = {pair.x2[SW-1], pair.x2} - {prev_reg[SW-1], prev_reg};
    assign coeff_s   = $signed({1'b0, coeff});
    assign prod_next = coeff_s * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= pair.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.vld)
        begin
            prod_reg <= prod_next;
            x1_reg   <= pair.x1;
        end
    end

    // Stage 2: x1 * 2^16 + half-LSB bias folded into the low bits, then shift
    assign acc = $signed({{(ACC_W - SW - 16){x1_reg[SW-1]}}, x1_reg, 16'h8000})
               + $signed({prod_reg[PROD_W-1], prod_reg});
    assign q   = acc[ACC_W-1:16];

    // Saturate when the bits above the sample width disagree with its sign
    always_comb
    begin
        if (q[Q_W-1:SW-1] == {(Q_W - SW + 1){1'b0}} ||
            q[Q_W-1:SW-1] == {(Q_W - SW + 1){1'b1}})
        begin
            y_next = q[SW-1:0];
        end
        else if (q[Q_W-1])
        begin
            y_next = {1'b1, {(SW - 1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(SW - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_vld_reg <= 1'b0;
            prev_reg  <= '0;
        end
        else
        begin
            y_vld_reg <= s1_vld_reg;
            if (s1_vld_reg)
            begin
                prev_reg <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            y_reg <= y_next;
        end
    end

    assign result.vld = y_vld_reg;
    assign result.y   = y_reg;

endmodule

`default_nettype wire

// ----- sv/fractional_delay_line_unit.sv -----
`default_nettype none

// Fractional delay line: a ring of 2^SIZE_LOG2 signed Q1.23 samples in one
// single-port synchronous memory. A write beat stores sample_in at the write
// pointer. A read beat with delay d fetches x1 at d and x2 at d+1 behind the
// pointer (offset 1 is the newest), one fetch after the other on the memory
// port, and no new beat is taken until the second fetch is done; writes go
// one per cycle while nothing holds them off. The result y = x1 + c*(x2 -
// y_prev), rounded and saturated, passes the memory read register, the x1
// register and the interpolator's product and output registers, then waits
// in a four-entry output queue; beats of either kind are held off once four
// results are queued or in flight. The ring reads as zero until written: the
// pointer and a wrap flag track which entries hold data, so there is no
// clearing pass after reset. The coefficient c (unsigned Q0.16, reset 0.5)
// is written on the cfg channel; the user must write it only while idle, as the block does not enforce this.
module fractional_delay_line_unit #(
    parameter int SIZE_LOG2 = fdl_pkg::SIZE_LOG2_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fdl_req_if.sink    req,
    fdl_res_if.source  res,
    fdl_cfg_if.sink    cfg
);

    localparam int RING_DEPTH = 1 << SIZE_LOG2;
    localparam int OFF_W      = fdl_pkg::DELAY_W + 1;
    localparam int AW         = (SIZE_LOG2 > OFF_W) ? SIZE_LOG2 : OFF_W;
    localparam int CW         = fdl_pkg::OUT_CNT_W;
    localparam int PW         = fdl_pkg::OUT_PTR_W;

    // Coefficient register
    logic [fdl_pkg::COEFF_W-1:0] coeff_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= fdl_pkg::COEFF_RESET;
        end
        else if (cfg.valid)
        begin
            coeff_reg <= cfg.data;
        end
    end

    // Control state
    logic [SIZE_LOG2-1:0] wp_reg, wp_next;
    logic                 wrapped_reg, wrapped_next;
    logic                 phase2_reg;
    logic                 x2ph_reg;
    logic [SIZE_LOG2-1:0] addr2_reg;
    logic                 v1_reg, v2_reg, v2_d_reg;
    logic [CW-1:0]        credit_reg, credit_next;

    logic                 req_ready;
    logic                 accept, rd_acc, wr_acc, pop;
    logic [OFF_W-1:0]     off1, off2;
    logic [AW-1:0]        addr1_w, addr2_w;
    logic [SIZE_LOG2-1:0] addr1, addr2;
    logic                 v1, v2;

    assign req_ready = !phase2_reg && (credit_reg != CW'(fdl_pkg::OUT_DEPTH));
    assign req.ready = req_ready;
    assign accept    = req.valid && req_ready;
    assign rd_acc    = accept && (req.req_type == fdl_pkg::REQ_READ);
    assign wr_acc    = accept && (req.req_type == fdl_pkg::REQ_WRITE);
    assign pop       = res.valid && res.ready;

    // Read addresses, modulo the ring size
    assign off1    = {1'b0, req.delay_int};
    assign off2    = off1 + 1'b1;
    assign addr1_w = AW'(wp_reg) - AW'(off1);
    assign addr2_w = AW'(wp_reg) - AW'(off2);
    assign addr1   = addr1_w[SIZE_LOG2-1:0];
    assign addr2   = addr2_w[SIZE_LOG2-1:0];

    // Entry holds data once the pointer has passed it or the ring has wrapped
    assign v1 = wrapped_reg || (addr1 < wp_reg);
    assign v2 = wrapped_reg || (addr2 < wp_reg);

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (wr_acc)
        begin
            wp_next = wp_reg + 1'b1;
            if (wp_reg == {SIZE_LOG2{1'b1}})
            begin
                wrapped_next = 1'b1;
            end
        end
    end

    assign credit_next = credit_reg + CW'(rd_acc) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            phase2_reg  <= 1'b0;
            x2ph_reg    <= 1'b0;
            credit_reg  <= '0;
        end
        else
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            phase2_reg  <= rd_acc;
            x2ph_reg    <= phase2_reg;
            credit_reg  <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_acc)
        begin
            addr2_reg <= addr2;
            v1_reg    <= v1;
            v2_reg    <= v2;
        end
        v2_d_reg <= v2_reg;
    end

    // Single-port ring memory
    fdl_pkg::sample_t     ring [RING_DEPTH];
    fdl_pkg::sample_t     rdata_reg;
    fdl_pkg::sample_t     x1_reg;
    logic [SIZE_LOG2-1:0] mem_addr;
    logic                 mem_re;

    assign mem_addr = phase2_reg ? addr2_reg : (wr_acc ? wp_reg : addr1);
    assign mem_re   = rd_acc || phase2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            ring[mem_addr] <= req.sample_in;
        end
        else if (mem_re)
        begin
            rdata_reg <= ring[mem_addr];
        end
    end

    // x1 arrives in the second fetch cycle, masked if never written
    always_ff @(posedge clk)
    begin
        if (phase2_reg)
        begin
            x1_reg <= v1_reg ? rdata_reg : '0;
        end
    end

    // Interpolator
    fdl_pkg::pair_t   pair;
    fdl_pkg::result_t result;

    assign pair.vld = x2ph_reg;
    assign pair.x1  = x1_reg;
    assign pair.x2  = v2_d_reg ? rdata_reg : '0;

    fdl_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .coeff  (coeff_reg),
        .pair   (pair),
        .result (result)
    );

    // Output queue
    fdl_pkg::sample_t q_mem [fdl_pkg::OUT_DEPTH];
    logic [PW-1:0]    q_wr_reg, q_rd_reg;
    logic [CW-1:0]    q_cnt_reg, q_cnt_next;

    assign q_cnt_next = q_cnt_reg + CW'(result.vld) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (result.vld)
            begin
                q_wr_reg <= q_wr_reg + 1'b1;
            end
            if (pop)
            begin
                q_rd_reg <= q_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.vld)
        begin
            q_mem[q_wr_reg] <= result.y;
        end
    end

    assign res.valid      = (q_cnt_reg != '0);
    assign res.sample_out = q_mem[q_rd_reg];

    // Checks
    a_port_busy: assert property (@(posedge clk) disable iff (!rst_n)
        phase2_reg |-> !req.ready)
        else $error("beat accepted while second fetch owns the memory port");

    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc |=> phase2_reg ##1 pair.vld)
        else $error("read fetch sequence broken");

    a_credit_max: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CW'(fdl_pkg::OUT_DEPTH))
        else $error("read credit overrun");

    a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= credit_reg)
        else $error("queued results exceed outstanding reads");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        result.vld |-> (q_cnt_reg != CW'(fdl_pkg::OUT_DEPTH)))
        else $error("result pushed into full queue");

endmodule

`default_nettype wire
